[rtl/viterbi_add_compare_select_core_macros.svh]
// Assertion macros shared by the add-compare-select decoder modules.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef VITERBI_ADD_COMPARE_SELECT_CORE_MACROS_SVH
`define VITERBI_ADD_COMPARE_SELECT_CORE_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define VACS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define VACS_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[rtl/vacs_pkg.sv]
// Shared constants, types and the branch distance function of the
// add-compare-select decoder. No dependencies.
package vacs_pkg;

   localparam int unsigned CONSTRAINT_LENGTH = 3;
   localparam int unsigned METRIC_WIDTH      = 16;
   localparam int unsigned NUM_STATES        = 1 << (CONSTRAINT_LENGTH - 1);
   localparam int unsigned NUM_BRANCHES      = 1 << CONSTRAINT_LENGTH;
   localparam int unsigned STATE_BITS        = CONSTRAINT_LENGTH - 1;
   localparam int unsigned SUM_WIDTH         = METRIC_WIDTH + 1;
   localparam int unsigned ROW_WIDTH         = 4;
   localparam int unsigned POLY_WIDTH        = 3;
   localparam int unsigned SYMBOL_WIDTH      = 2;
   localparam int unsigned DIST_WIDTH        = 2;
   localparam int unsigned CSR_INDEX_WIDTH   = 1;
   localparam int unsigned CSR_DATA_WIDTH    = 3;
   localparam int unsigned QUEUE_DEPTH       = 2;
   localparam int unsigned QUEUE_PTR_WIDTH   = 1;
   localparam int unsigned QUEUE_COUNT_WIDTH = 2;

   typedef logic [METRIC_WIDTH-1:0] metric_type;
   typedef logic [DIST_WIDTH-1:0]   dist_type;
   typedef logic [POLY_WIDTH-1:0]   poly_type;

   localparam poly_type   POLY_UPPER_RESET = 3'd5;
   localparam poly_type   POLY_LOWER_RESET = 3'd7;
   localparam metric_type METRIC_ZERO      = '0;
   localparam metric_type METRIC_MAX       = '1;
   localparam metric_type METRIC_INIT      = {2'b01, {(METRIC_WIDTH - 2){1'b0}}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POLY_UPPER = 1'b0,
      CSR_POLY_LOWER = 1'b1
   } csr_index_type;

   // One classified symbol: the distance of every branch label to it.
   typedef struct packed {
      logic                               frame_start;
      logic [NUM_BRANCHES-1:0][DIST_WIDTH-1:0] branch_dist;
   } step_type;

   typedef struct packed {
      logic     valid;
      step_type step;
   } queue_head_type;

   // Hamming distance between a received symbol and the symbol expected on
   // the branch whose encoder register holds shift_bits.
   function automatic dist_type branch_distance(
      input logic [CONSTRAINT_LENGTH-1:0] shift_bits,
      input poly_type                     poly_upper,
      input poly_type                     poly_lower,
      input logic [SYMBOL_WIDTH-1:0]      rx_symbol
   );
      logic [CONSTRAINT_LENGTH-1:0] mask_upper;
      logic [CONSTRAINT_LENGTH-1:0] mask_lower;
      logic [SYMBOL_WIDTH-1:0]      expected;
      logic [SYMBOL_WIDTH-1:0]      diff;
      mask_upper = '0;
      mask_lower = '0;
      mask_upper[POLY_WIDTH-1:0] = poly_upper;
      mask_lower[POLY_WIDTH-1:0] = poly_lower;
      expected[1] = ^(shift_bits & mask_upper);
      expected[0] = ^(shift_bits & mask_lower);
      diff = expected ^ rx_symbol;
      return {1'b0, diff[1]} + {1'b0, diff[0]};
   endfunction

endpackage

[rtl/vacs_front.sv]
// Front end: polynomial registers, request handshake and branch distance
// classification of each received symbol. Depends on vacs_pkg.
module vacs_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [vacs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [vacs_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [vacs_pkg::SYMBOL_WIDTH-1:0]      req_rx_symbol,
   input  logic                                   req_frame_start,
   input  logic                                   queue_full,
   output logic                                   push,
   output vacs_pkg::step_type                     push_step
);

   vacs_pkg::poly_type poly_upper_ff, poly_upper_in;
   vacs_pkg::poly_type poly_lower_ff, poly_lower_in;

   always_comb begin
      poly_upper_in = poly_upper_ff;
      poly_lower_in = poly_lower_ff;
      if (csr_write_enable) begin
         case (vacs_pkg::csr_index_type'(csr_index))
            vacs_pkg::CSR_POLY_UPPER: poly_upper_in = csr_write_data[vacs_pkg::POLY_WIDTH-1:0];
            vacs_pkg::CSR_POLY_LOWER: poly_lower_in = csr_write_data[vacs_pkg::POLY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_upper_ff <= vacs_pkg::POLY_UPPER_RESET;
         poly_lower_ff <= vacs_pkg::POLY_LOWER_RESET;
      end else begin
         poly_upper_ff <= poly_upper_in;
         poly_lower_ff <= poly_lower_in;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_step.frame_start = req_frame_start;
      for (int b = 0; b < vacs_pkg::NUM_BRANCHES; b++) begin
         push_step.branch_dist[b] = vacs_pkg::branch_distance(
            vacs_pkg::CONSTRAINT_LENGTH'(b), poly_upper_ff, poly_lower_ff, req_rx_symbol);
      end
   end

endmodule

[rtl/vacs_queue.sv]
// Two-entry queue of classified symbols between front and back ends.
// Depends on vacs_pkg and the assertion macro header.
`include "viterbi_add_compare_select_core_macros.svh"

module vacs_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  vacs_pkg::step_type       push_step,
   input  logic                     pop,
   output vacs_pkg::queue_head_type head,
   output logic                     full
);

   vacs_pkg::step_type entries_ff [vacs_pkg::QUEUE_DEPTH];
   logic [vacs_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [vacs_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [vacs_pkg::QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                                   do_pop;

   assign full       = (count_ff == vacs_pkg::QUEUE_COUNT_WIDTH'(vacs_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.step  = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_step;
      end
   end

   `VACS_ASSERT(a_count_bounded, count_ff <= vacs_pkg::QUEUE_COUNT_WIDTH'(vacs_pkg::QUEUE_DEPTH), "queue count beyond depth")
   `VACS_ASSERT(a_pop_drains, (do_pop && !push) |=> (count_ff == $past(count_ff) - 1'b1), "pop did not drain an entry")

endmodule

[rtl/vacs_back.sv]
// Back end: path metric registers, parallel add-compare-select over all
// trellis states and the survivor row output register. Depends on vacs_pkg
// and the assertion macro header.
`include "viterbi_add_compare_select_core_macros.svh"

module vacs_back (
   input  logic                                clock,
   input  logic                                reset,
   input  vacs_pkg::queue_head_type            head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [vacs_pkg::ROW_WIDTH-1:0]      rsp_survivor_row
);

   vacs_pkg::metric_type metric_ff [vacs_pkg::NUM_STATES];
   vacs_pkg::metric_type metric_in [vacs_pkg::NUM_STATES];
   vacs_pkg::metric_type base      [vacs_pkg::NUM_STATES];
   logic [vacs_pkg::NUM_STATES-1:0] decision;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [vacs_pkg::ROW_WIDTH-1:0]  row_ff, row_in;
   logic                            take;

   assign take = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;

   // A frame start restarts the trellis from state zero before the step.
   always_comb begin
      for (int s = 0; s < vacs_pkg::NUM_STATES; s++) begin
         if (head.step.frame_start) begin
            base[s] = (s == 0) ? vacs_pkg::METRIC_ZERO : vacs_pkg::METRIC_INIT;
         end else begin
            base[s] = metric_ff[s];
         end
      end
   end

   always_comb begin
      logic [vacs_pkg::SUM_WIDTH-1:0] sum0;
      logic [vacs_pkg::SUM_WIDTH-1:0] sum1;
      vacs_pkg::metric_type           m0;
      vacs_pkg::metric_type           m1;
      for (int s = 0; s < vacs_pkg::NUM_STATES; s++) begin
         sum0 = {1'b0, base[vacs_pkg::STATE_BITS'(s >> 1)]}
              + vacs_pkg::SUM_WIDTH'(head.step.branch_dist[s]);
         sum1 = {1'b0, base[vacs_pkg::STATE_BITS'((s >> 1) + (vacs_pkg::NUM_STATES >> 1))]}
              + vacs_pkg::SUM_WIDTH'(head.step.branch_dist[s + vacs_pkg::NUM_STATES]);
         m0 = sum0[vacs_pkg::METRIC_WIDTH] ? vacs_pkg::METRIC_MAX
                                           : sum0[vacs_pkg::METRIC_WIDTH-1:0];
         m1 = sum1[vacs_pkg::METRIC_WIDTH] ? vacs_pkg::METRIC_MAX
                                           : sum1[vacs_pkg::METRIC_WIDTH-1:0];
         decision[s] = (m1 < m0);
         metric_in[s] = take ? (decision[s] ? m1 : m0) : metric_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < vacs_pkg::NUM_STATES; s++) begin
            metric_ff[s] <= (s == 0) ? vacs_pkg::METRIC_ZERO : vacs_pkg::METRIC_INIT;
         end
      end else begin
         for (int s = 0; s < vacs_pkg::NUM_STATES; s++) begin
            metric_ff[s] <= metric_in[s];
         end
      end
   end

   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);
   assign row_in       = take ? decision[vacs_pkg::ROW_WIDTH-1:0] : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_survivor_row = row_ff;

   `VACS_ASSERT(a_take_fills_output, take |=> rsp_valid_ff, "taken step left no result")
   `VACS_ASSERT(a_frame_start_zero, (take && head.step.frame_start) |=> (metric_ff[0] <= vacs_pkg::metric_type'(2)), "state zero metric not restarted")

endmodule

[rtl/viterbi_add_compare_select_core.sv]
// Top level of the hard-decision add-compare-select decoder core.
// Depends on vacs_pkg, vacs_front, vacs_queue and vacs_back.
//
//   Port group   Direction   Handshake          Payload
//   req_*        in          valid / stall      rx_symbol (2 bits), frame_start (1 bit)
//   rsp_*        out         valid / stall      survivor_row (4 bits)
//   csr_*        in          write enable only  index (1 bit), write data (3 bits)
//
// One received symbol is taken every cycle while the result side keeps up.
// A request accepted into the queue passes through the add-compare-select stage
// when the back end takes it; its survivor row is then held in the output
// register on rsp_* until it is taken.
// The parallel path metric update of all trellis states sets that intake rate.
// Synchronous reset empties the queue and output register, restores the default
// polynomials and loads the initial metrics; no clearing pass is needed.
// A stall on rsp_* holds the output; the queue then fills and raises req_stall.
module viterbi_add_compare_select_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [vacs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [vacs_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [vacs_pkg::SYMBOL_WIDTH-1:0]      req_rx_symbol,
   input  logic                                   req_frame_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [vacs_pkg::ROW_WIDTH-1:0]         rsp_survivor_row
);

   // Handshake between the front end and the queue.
   logic                     push;
   vacs_pkg::step_type       push_step;
   logic                     queue_full;

   // Head of the queue as seen by the back end.
   vacs_pkg::queue_head_type head;
   logic                     pop;

   // The front end holds the generator polynomials and turns each symbol into
   // the distances of all branch labels, so the back end never sees them.
   vacs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_symbol    (req_rx_symbol),
      .req_frame_start  (req_frame_start),
      .queue_full       (queue_full),
      .push             (push),
      .push_step        (push_step)
   );

   // The two-entry queue lets the request side keep going while the result side
   // stalls, until the queue fills.
   vacs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_step (push_step),
      .pop       (pop),
      .head      (head),
      .full      (queue_full)
   );

   // The back end runs one trellis step per cycle unless stalled; it registers the row.
   vacs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_survivor_row (rsp_survivor_row)
   );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the add-compare-select decoder core, which it drives as u_top.
// It depends on vacs_pkg and the core RTL only. Survivor rows are predicted by a local trellis
// model and checked in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_COUNT = 20;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_REQUESTS = 216;
   // Every branch costs two when all labels are zero and the symbol is 3, so the lowest metric
   // climbs by two per request and, once the metrics have met, every decision is a tie.
   localparam int SOAK_REQUESTS  = 40;

   // One row of the directed script. Where fixed is set, row holds a survivor row that
   // can be worked out by hand. Otherwise the trellis model supplies the expectation.
   typedef struct packed {
      logic [1:0] sym;
      logic       frame;
      logic       fixed;
      logic [3:0] row;
   } directed_step_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  csr_write_enable;
   logic [vacs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [vacs_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [vacs_pkg::SYMBOL_WIDTH-1:0]     req_rx_symbol;
   logic                                  req_frame_start;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [vacs_pkg::ROW_WIDTH-1:0]        rsp_survivor_row;

   // The trellis model keeps its own copy of the polynomials and the path metrics.
   vacs_pkg::poly_type   poly_upper_now;
   vacs_pkg::poly_type   poly_lower_now;
   vacs_pkg::metric_type trellis_metric [vacs_pkg::NUM_STATES];

   logic [3:0] survivor_rows_due [$];
   logic [3:0] due_row;
   int         mismatch_count;
   bit         quiet_traffic;

   // The first rows start from the reset metrics, or reload them with a frame start. In all
   // of them state 0 wins outright for states 0 and 1, and states 2 and 3 see equal sums,
   // so the tie rule keeps the lower predecessor. The row is therefore zero.
   directed_step_type directed_steps [DIRECTED_COUNT] = '{
      '{2'd0, 1'b0, 1'b1, 4'h0},
      '{2'd0, 1'b1, 1'b1, 4'h0},
      '{2'd3, 1'b1, 1'b1, 4'h0},
      '{2'd1, 1'b0, 1'b0, 4'h0},
      '{2'd2, 1'b0, 1'b0, 4'h0},
      '{2'd3, 1'b0, 1'b0, 4'h0},
      '{2'd0, 1'b0, 1'b0, 4'h0},
      '{2'd3, 1'b0, 1'b0, 4'h0},
      '{2'd3, 1'b0, 1'b0, 4'h0},
      '{2'd1, 1'b1, 1'b0, 4'h0},
      '{2'd2, 1'b0, 1'b0, 4'h0},
      '{2'd2, 1'b0, 1'b0, 4'h0},
      '{2'd1, 1'b0, 1'b0, 4'h0},
      '{2'd0, 1'b0, 1'b0, 4'h0},
      '{2'd3, 1'b1, 1'b0, 4'h0},
      '{2'd3, 1'b0, 1'b0, 4'h0},
      '{2'd0, 1'b0, 1'b0, 4'h0},
      '{2'd1, 1'b0, 1'b0, 4'h0},
      '{2'd2, 1'b0, 1'b0, 4'h0},
      '{2'd3, 1'b0, 1'b0, 4'h0}
   };

   viterbi_add_compare_select_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_symbol    (req_rx_symbol),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_survivor_row (rsp_survivor_row)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit. The slowest legal run is well under a fifth of it.
   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void load_initial_metrics();
      for (int s = 0; s < vacs_pkg::NUM_STATES; s++) begin
         trellis_metric[s] = (s == 0) ? vacs_pkg::METRIC_ZERO : vacs_pkg::METRIC_INIT;
      end
   endfunction

   // One add-compare-select step over the four states. For each state it takes the two
   // predecessors, which differ only in the top bit. Each branch sum is saturated. The
   // lower predecessor wins a tie.
   function automatic logic [3:0] predict_survivors(input logic [1:0] sym,
                                                    input logic fresh_frame);
      vacs_pkg::metric_type           next_metric [vacs_pkg::NUM_STATES];
      logic [vacs_pkg::SUM_WIDTH-1:0] branch_sum [2];
      logic [2:0]                     shift_bits;
      logic [1:0]                     pred;
      logic [1:0]                     label;
      logic [3:0]                     row;
      row = '0;
      if (fresh_frame) begin
         load_initial_metrics();
      end
      for (int s = 0; s < vacs_pkg::NUM_STATES; s++) begin
         for (int k = 0; k < 2; k++) begin
            pred       = {k[0], s[1]};
            shift_bits = {pred, s[0]};
            label      = {^(shift_bits & poly_upper_now), ^(shift_bits & poly_lower_now)};
            branch_sum[k] = {1'b0, trellis_metric[pred]}
                            + vacs_pkg::SUM_WIDTH'(label[1] ^ sym[1])
                            + vacs_pkg::SUM_WIDTH'(label[0] ^ sym[0]);
            if (branch_sum[k] > {1'b0, vacs_pkg::METRIC_MAX}) begin
               branch_sum[k] = {1'b0, vacs_pkg::METRIC_MAX};
            end
         end
         if (branch_sum[1] < branch_sum[0]) begin
            next_metric[s] = branch_sum[1][vacs_pkg::METRIC_WIDTH-1:0];
            row[s]         = 1'b1;
         end else begin
            next_metric[s] = branch_sum[0][vacs_pkg::METRIC_WIDTH-1:0];
         end
      end
      trellis_metric = next_metric;
      return row;
   endfunction

   // Gap lengths are mostly zero or short, with the occasional long one. Quiet phases
   // run flat out.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_traffic || roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end else begin
         return $urandom_range(20, 40);
      end
   endfunction

   // The result side stalls in runs of random length. A run of stalls starts on roughly
   // one negative edge in four. Each negative edge sees at most one assignment.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_traffic && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat (pick_gap()) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Sends one request after a random gap and waits until it is taken. The expectation is
   // queued at the accepting edge, so the model sees the requests in the core's own order.
   task automatic push_request(input logic [1:0] sym, input logic fresh_frame,
                               input logic fixed, input logic [3:0] fixed_row);
      int         gap;
      logic [3:0] predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_rx_symbol   = sym;
      req_frame_start = fresh_frame;
      do @(posedge clock); while (req_stall);
      predicted = predict_survivors(sym, fresh_frame);
      survivor_rows_due.push_back(fixed ? fixed_row : predicted);
   endtask

   // Drops valid, waits for every outstanding survivor row and then lets the core run idle.
   // The core holds at most three requests in flight.
   task automatic wait_until_settled();
      @(negedge clock);
      req_valid = 1'b0;
      while (survivor_rows_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // The configuration writes affect only the polynomials. The path metrics carry over.
   task automatic write_register(input vacs_pkg::csr_index_type which,
                                 input vacs_pkg::poly_type value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = which;
      csr_write_data   = value;
      @(posedge clock);
      if (which == vacs_pkg::CSR_POLY_UPPER) begin
         poly_upper_now = value;
      end else begin
         poly_lower_now = value;
      end
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Every accepted survivor row is compared with the oldest one still due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (survivor_rows_due.size() == 0) begin
            $display("%0t: survivor row expected nothing, got %h",
                     $time, rsp_survivor_row);
            mismatch_count++;
         end else begin
            due_row = survivor_rows_due.pop_front();
            if (rsp_survivor_row !== due_row) begin
               $display("%0t: survivor row expected %h, got %h",
                        $time, due_row, rsp_survivor_row);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int                 phase;
      int                 sent;
      int                 frame_len;
      int                 flip_bit;
      logic [1:0]         sym;
      logic [1:0]         enc_state;
      logic [2:0]         shift_bits;
      logic               fresh_frame;
      logic               data_bit;
      logic               noisy;
      vacs_pkg::poly_type new_upper;
      vacs_pkg::poly_type new_lower;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_symbol    = '0;
      req_frame_start  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = vacs_pkg::CSR_POLY_UPPER;
      csr_write_data   = '0;
      quiet_traffic    = 1'b0;
      mismatch_count   = 0;
      poly_upper_now   = vacs_pkg::POLY_UPPER_RESET;
      poly_lower_now   = vacs_pkg::POLY_LOWER_RESET;
      load_initial_metrics();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // The directed script runs on the default polynomials, so it also checks the
      // values that the registers take at reset.
      foreach (directed_steps[i]) begin
         push_request(directed_steps[i].sym, directed_steps[i].frame,
                      directed_steps[i].fixed, directed_steps[i].row);
      end
      wait_until_settled();

      // The random phases each use a new pair of polynomials, starting with the extremes.
      // Most frames carry a properly encoded stream from state 0 with the odd symbol bit
      // flipped, so the metrics stay low and the decisions follow real paths. The rest are
      // noise frames. The third phase runs with no gaps and no stalls at all.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               new_upper = 3'd7;
               new_lower = 3'd7;
            end
            1: begin
               new_upper = 3'd0;
               new_lower = 3'd0;
            end
            2: begin
               new_upper = 3'd7;
               new_lower = 3'd0;
            end
            3: begin
               new_upper = 3'd0;
               new_lower = 3'd7;
            end
            default: begin
               new_upper = vacs_pkg::poly_type'($urandom_range(0, 7));
               new_lower = vacs_pkg::poly_type'($urandom_range(0, 7));
            end
         endcase
         write_register(vacs_pkg::CSR_POLY_UPPER, new_upper);
         write_register(vacs_pkg::CSR_POLY_LOWER, new_lower);
         quiet_traffic = (phase == 2);
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            frame_len = $urandom_range(8, 60);
            noisy     = ($urandom_range(0, 4) == 0);
            enc_state = '0;
            for (int j = 0; j < frame_len && sent < PHASE_REQUESTS; j++) begin
               if (noisy) begin
                  sym         = 2'($urandom_range(0, 3));
                  fresh_frame = (j == 0) || ($urandom_range(0, 19) == 0);
               end else begin
                  data_bit   = 1'($urandom_range(0, 1));
                  shift_bits = {enc_state, data_bit};
                  sym        = {^(shift_bits & poly_upper_now),
                                ^(shift_bits & poly_lower_now)};
                  enc_state  = shift_bits[1:0];
                  if ($urandom_range(0, 15) == 0) begin
                     flip_bit      = $urandom_range(0, 1);
                     sym[flip_bit] = ~sym[flip_bit];
                  end
                  // Now and then a frame runs on without a restart, so the metrics carry
                  // over from the frame before.
                  fresh_frame = (j == 0) && ($urandom_range(0, 9) != 0);
               end
               push_request(sym, fresh_frame, 1'b0, 4'h0);
               sent++;
            end
         end
         wait_until_settled();
      end

      // Climbing metrics. With both polynomials cleared, every branch label is zero. With
      // symbol 3 every branch then costs two, so the metrics meet and then climb together, and
      // from that point every decision is a tie.
      quiet_traffic = 1'b1;
      write_register(vacs_pkg::CSR_POLY_UPPER, 3'd0);
      write_register(vacs_pkg::CSR_POLY_LOWER, 3'd0);
      push_request(2'd3, 1'b1, 1'b0, 4'h0);
      for (int j = 1; j < SOAK_REQUESTS; j++) begin
         push_request(2'd3, 1'b0, 1'b0, 4'h0);
      end
      wait_until_settled();

      // The raised metrics carry over into steps with unequal branch distances, and then a
      // frame start brings them back down.
      quiet_traffic = 1'b0;
      write_register(vacs_pkg::CSR_POLY_UPPER, vacs_pkg::poly_type'($urandom_range(0, 7)));
      write_register(vacs_pkg::CSR_POLY_LOWER, vacs_pkg::poly_type'($urandom_range(0, 7)));
      for (int j = 0; j < 40; j++) begin
         push_request(2'($urandom_range(0, 3)), 1'b0, 1'b0, 4'h0);
      end
      for (int j = 0; j < 20; j++) begin
         push_request(2'($urandom_range(0, 3)), j == 0, 1'b0, 4'h0);
      end
      wait_until_settled();

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
